/* design/cre_pkg.sv */
// shared types, constants and character class helpers for the range expander
`timescale 1ns / 1ps

package cre_pkg;

    localparam int unsigned CHAR_W = 8;

    localparam logic [CHAR_W-1:0] DASH_CHAR = 8'h2D;

    // character classes that can form a range
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_DIGIT = 2'd1,
        CLS_UPPER = 2'd2,
        CLS_LOWER = 2'd3
    } char_class_t;

    // controller states
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_EXPAND = 2'd1,
        ST_CHAR   = 2'd2
    } ctrl_state_t;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_IN_PLAIN = 3'd1,
        OP_IN_RANGE = 3'd2,
        OP_IN_DASH  = 3'd3,
        OP_EXP_STEP = 3'd4,
        OP_CUR_EMIT = 3'd5
    } dp_op_t;

    // command from controller to datapath
    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic dash_held;
        logic range_hit;
        logic in_hold;
        logic cnt_end;
    } dp_status_t;

    function automatic char_class_t class_of(input logic [CHAR_W-1:0] c);
        char_class_t cls;
        cls = CLS_NONE;
        if (c inside {[8'h30:8'h39]})
            cls = CLS_DIGIT;
        else if (c inside {[8'h41:8'h5A]})
            cls = CLS_UPPER;
        else if (c inside {[8'h61:8'h7A]})
            cls = CLS_LOWER;
        return cls;
    endfunction

    function automatic logic range_ok(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
        char_class_t ca;
        ca = class_of(a);
        return (ca != CLS_NONE) && (ca == class_of(b)) && (a < b);
    endfunction

endpackage

/* design/cre_dpath.sv */
// datapath: history registers, range counter and output register
`timescale 1ns / 1ps

module cre_dpath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [cre_pkg::CHAR_W-1:0] in_char,
    input  logic                       in_last,
    input  logic                       m_tready,
    input  cre_pkg::dp_cmd_t           cmd,
    output cre_pkg::dp_status_t        status,
    output logic [cre_pkg::CHAR_W-1:0] out_char,
    output logic                       out_last,
    output logic                       out_valid
);
    import cre_pkg::*;

    logic [CHAR_W-1:0] prior_char_reg, prior_char_next;
    logic              prior_valid_reg, prior_valid_next;
    logic              dash_held_reg, dash_held_next;
    logic [CHAR_W-1:0] cur_char_reg, cur_char_next;
    logic              cur_last_reg, cur_last_next;
    logic [CHAR_W-1:0] cnt_reg, cnt_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg, out_valid_next;

    logic in_hold;
    logic cnt_end;

    // decode of the incoming character and counter
    assign in_hold = (in_char == DASH_CHAR) && !in_last;
    assign cnt_end = (cnt_reg == cur_char_reg);

    // status toward the controller
    always_comb
    begin
        status.out_free  = !out_valid_reg || m_tready;
        status.dash_held = dash_held_reg;
        status.range_hit = prior_valid_reg && range_ok(prior_char_reg, in_char);
        status.in_hold   = in_hold;
        status.cnt_end   = cnt_end;
    end

    // next-state of history, counter and output register
    always_comb
    begin
        prior_char_next  = prior_char_reg;
        prior_valid_next = prior_valid_reg;
        dash_held_next   = dash_held_reg;
        cur_char_next    = cur_char_reg;
        cur_last_next    = cur_last_reg;
        cnt_next         = cnt_reg;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        case (cmd.op)
            OP_IN_PLAIN:
            begin
                if (in_hold)
                begin
                    dash_held_next = 1'b1;
                end
                else
                begin
                    out_char_next  = in_char;
                    out_last_next  = in_last;
                    out_valid_next = 1'b1;
                    if (in_last)
                    begin
                        prior_char_next  = '0;
                        prior_valid_next = 1'b0;
                        dash_held_next   = 1'b0;
                    end
                    else
                    begin
                        prior_char_next  = in_char;
                        prior_valid_next = 1'b1;
                    end
                end
            end
            OP_IN_RANGE:
            begin
                cur_char_next  = in_char;
                cur_last_next  = in_last;
                cnt_next       = prior_char_reg + CHAR_W'(1);
                dash_held_next = 1'b0;
            end
            OP_IN_DASH:
            begin
                out_char_next    = DASH_CHAR;
                out_last_next    = 1'b0;
                out_valid_next   = 1'b1;
                prior_char_next  = DASH_CHAR;
                prior_valid_next = 1'b1;
                dash_held_next   = in_hold;
                cur_char_next    = in_char;
                cur_last_next    = in_last;
            end
            OP_EXP_STEP:
            begin
                out_char_next  = cnt_reg;
                out_last_next  = cur_last_reg && cnt_end;
                out_valid_next = 1'b1;
                cnt_next       = cnt_reg + CHAR_W'(1);
                if (cnt_end)
                begin
                    if (cur_last_reg)
                    begin
                        prior_char_next  = '0;
                        prior_valid_next = 1'b0;
                    end
                    else
                    begin
                        prior_char_next  = cur_char_reg;
                        prior_valid_next = 1'b1;
                    end
                end
            end
            OP_CUR_EMIT:
            begin
                out_char_next  = cur_char_reg;
                out_last_next  = cur_last_reg;
                out_valid_next = 1'b1;
                if (cur_last_reg)
                begin
                    prior_char_next  = '0;
                    prior_valid_next = 1'b0;
                    dash_held_next   = 1'b0;
                end
                else
                begin
                    prior_char_next  = cur_char_reg;
                    prior_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_char_reg  <= '0;
            prior_valid_reg <= 1'b0;
            dash_held_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prior_char_reg  <= prior_char_next;
            prior_valid_reg <= prior_valid_next;
            dash_held_reg   <= dash_held_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_char_reg <= cur_char_next;
        cur_last_reg <= cur_last_next;
        cnt_reg      <= cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

/* design/cre_ctrl.sv */
// controller: sequences input transfers, range expansion and pending characters
`timescale 1ns / 1ps

module cre_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cre_pkg::dp_status_t status,
    output cre_pkg::dp_cmd_t    cmd
);
    import cre_pkg::*;

    ctrl_state_t state_reg, state_next;

    logic take;

    assign take = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                if (take && status.dash_held)
                begin
                    if (status.range_hit)
                        state_next = ST_EXPAND;
                    else if (!status.in_hold)
                        state_next = ST_CHAR;
                end
            end
            ST_EXPAND:
            begin
                if (status.out_free && status.cnt_end)
                    state_next = ST_ACCEPT;
            end
            ST_CHAR:
            begin
                if (status.out_free)
                    state_next = ST_ACCEPT;
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // outputs: ready and datapath command
    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_ACCEPT:
            begin
                s_tready = status.out_free;
                if (take)
                begin
                    if (!status.dash_held)
                        cmd.op = OP_IN_PLAIN;
                    else if (status.range_hit)
                        cmd.op = OP_IN_RANGE;
                    else
                        cmd.op = OP_IN_DASH;
                end
            end
            ST_EXPAND:
            begin
                if (status.out_free)
                    cmd.op = OP_EXP_STEP;
            end
            ST_CHAR:
            begin
                if (status.out_free)
                    cmd.op = OP_CUR_EMIT;
            end
            default:
            begin
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACCEPT;
        else
            state_reg <= state_next;
    end

endmodule

/* design/char_range_expander.sv */
// top level of the character range expander: controller plus datapath
// a plain character is registered and appears on the output in the cycle after its transfer
// throughput: one character per cycle while nothing expands and the output is not stalled;
//   a range a-b first loads the expansion counter, then emits a+1 through b from it
// a dash followed by a character that is neither a range end nor a dash emits the dash,
// then that character from ST_CHAR; reset: rst_n asynchronous active low, clears history, held dash and output valid
`timescale 1ns / 1ps

module char_range_expander
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);
    import cre_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    cre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and output register
    cre_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_valid (m_tvalid)
    );

endmodule
